/* design/iac_pkg.sv */
// Package of types, codes and constants shared by the intrusion alarm controller.
`default_nettype none

package iac_pkg;

    // Field widths of the transfers
    localparam int INST_W  = 4;
    localparam int DLY_W   = 2;
    localparam int KEY_W   = 4;
    localparam int ENTRY_W = 32;
    localparam int SHOWN_W = 14;

    // Number of sensor inputs that are wired; upper field bits are ignored
    localparam int INSTANT_ZONE_COUNT = 4;
    localparam int DELAYED_ZONE_COUNT = 2;

    localparam logic [INST_W-1:0] INST_MASK = INST_W'((1 << INSTANT_ZONE_COUNT) - 1);
    localparam logic [DLY_W-1:0]  DLY_MASK  = DLY_W'((1 << DELAYED_ZONE_COUNT) - 1);

    // Action codes
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [KEY_W-1:0] KEY_STAR       = 4'd10;
    localparam logic [KEY_W-1:0] KEY_ENTER      = 4'd11;

    // Default settings
    localparam logic [6:0]  ARM_CODE_DEFAULT    = 7'd33;
    localparam logic [13:0] DISARM_CODE_DEFAULT = 14'd1236;
    localparam logic [6:0]  EXIT_DELAY_DEFAULT  = 7'd20;
    localparam logic [7:0]  SIREN_LIMIT_DEFAULT = 8'd180;
    localparam logic [9:0]  SIREN_LIMIT_MAX     = 10'd180;

    // Programming command ranges: a command is its base plus the new value
    localparam logic [ENTRY_W-1:0] PROG_ARM_LO    = 32'd1000;
    localparam logic [ENTRY_W-1:0] PROG_ARM_HI    = 32'd1099;
    localparam logic [ENTRY_W-1:0] PROG_DISARM_LO = 32'd110000;
    localparam logic [ENTRY_W-1:0] PROG_DISARM_HI = 32'd119999;
    localparam logic [ENTRY_W-1:0] PROG_EXIT_LO   = 32'd2000;
    localparam logic [ENTRY_W-1:0] PROG_EXIT_HI   = 32'd2099;
    localparam logic [ENTRY_W-1:0] PROG_SIREN_LO  = 32'd30000;
    localparam logic [ENTRY_W-1:0] PROG_SIREN_HI  = 32'd30999;
    localparam logic [ENTRY_W-1:0] CMD_DEFAULTS   = 32'd99000;

    localparam logic [7:0] SECONDS_MAX = 8'd255;

    typedef enum logic [3:0] {
        MSG_NONE        = 4'd0,
        MSG_ARMED       = 4'd1,
        MSG_CLEARED     = 4'd2,
        MSG_DISARMED    = 4'd3,
        MSG_NOT_ARMED   = 4'd4,
        MSG_NEW_ARM     = 4'd5,
        MSG_NEW_DISARM  = 4'd6,
        MSG_NEW_EXIT    = 4'd7,
        MSG_NEW_SIREN   = 4'd8,
        MSG_TOO_LONG    = 4'd9,
        MSG_DEFAULTS    = 4'd10
    } msg_t;

    // One accepted input item as held in the input register
    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key;
        logic [INST_W-1:0] instant_zones;
        logic [DLY_W-1:0]  delayed_zones;
    } iac_step_t;

    // One result item
    typedef struct packed {
        logic               armed_led;
        logic               siren_on;
        logic               buzzer_on;
        logic [INST_W-1:0]  zone_leds;
        logic [DLY_W-1:0]   delayed_leds;
        logic               alarm_tripped;
        msg_t               message;
        logic [SHOWN_W-1:0] shown_value;
    } iac_result_t;

endpackage

`default_nettype wire

/* design/iac_if.sv */
// Handshake interfaces for the input and result channels.
`default_nettype none

interface iac_item_if
    import iac_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [KEY_W-1:0]  key;
    logic [INST_W-1:0] instant_zones;
    logic [DLY_W-1:0]  delayed_zones;

    modport source (output valid, action, key, instant_zones, delayed_zones, input ready);
    modport sink   (input valid, action, key, instant_zones, delayed_zones, output ready);
endinterface

interface iac_result_if
    import iac_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               armed_led;
    logic               siren_on;
    logic               buzzer_on;
    logic [INST_W-1:0]  zone_leds;
    logic [DLY_W-1:0]   delayed_leds;
    logic               alarm_tripped;
    logic [3:0]         message;
    logic [SHOWN_W-1:0] shown_value;

    modport source (output valid, armed_led, siren_on, buzzer_on, zone_leds, delayed_leds,
                    alarm_tripped, message, shown_value, input ready);
    modport sink   (input valid, armed_led, siren_on, buzzer_on, zone_leds, delayed_leds,
                    alarm_tripped, message, shown_value, output ready);
endinterface

`default_nettype wire

/* design/intrusion_alarm_controller_top.sv */
// Top level of the intrusion alarm controller: input register, alarm logic, result register.
//
//   Channel  Role   Payload
//   item     sink   action, key, instant_zones, delayed_zones
//   result   source armed_led, siren_on, buzzer_on, zone_leds, delayed_leds,
//                   alarm_tripped, message, shown_value
//
// Each item passes from its transfer on item to its result on result through the input
// register and then through the alarm logic into the result register. A new item is
// taken in every cycle unless result stalls; the alarm state updates as each item moves on.
// Reset (rst_n low, asynchronous) empties both registers, clears the entry and the alarm
// state and loads the default codes, exit delay and siren limit.
// When result is stalled the result register holds its item and the input register can
// still take one more, so item stays ready until both hold an item.
`default_nettype none

module intrusion_alarm_controller_top
    import iac_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    iac_item_if.sink       item,
    iac_result_if.source   result
);

    iac_step_t          step_reg;
    logic               step_valid_reg, step_valid_next;
    iac_result_t        result_reg;
    iac_result_t        result_next;
    logic               result_valid_reg, result_valid_next;
    logic               out_free;
    logic               fire;
    logic [ENTRY_W-1:0] entry_value;

    // The held item moves on whenever the result register is empty or being emptied
    assign out_free   = !result_valid_reg || result.ready;
    assign fire       = step_valid_reg && out_free;
    assign item.ready = !step_valid_reg || fire;

    always_comb
    begin
        step_valid_next = step_valid_reg;
        if (item.valid && item.ready)
        begin
            step_valid_next = 1'b1;
        end
        else if (fire)
        begin
            step_valid_next = 1'b0;
        end

        result_valid_next = result_valid_reg;
        if (fire)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_valid_reg   <= step_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            step_reg.action        <= item.action;
            step_reg.key           <= item.key;
            step_reg.instant_zones <= item.instant_zones;
            step_reg.delayed_zones <= item.delayed_zones;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    iac_entry u_entry (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .step  (step_reg),
        .value (entry_value)
    );

    iac_panel u_panel (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .step        (step_reg),
        .entry_value (entry_value),
        .result      (result_next)
    );

    assign result.valid         = result_valid_reg;
    assign result.armed_led     = result_reg.armed_led;
    assign result.siren_on      = result_reg.siren_on;
    assign result.buzzer_on     = result_reg.buzzer_on;
    assign result.zone_leds     = result_reg.zone_leds;
    assign result.delayed_leds  = result_reg.delayed_leds;
    assign result.alarm_tripped = result_reg.alarm_tripped;
    assign result.message       = result_reg.message;
    assign result.shown_value   = result_reg.shown_value;

endmodule

`default_nettype wire

/* design/iac_entry.sv */
// Keypad entry accumulator: decimal digit append with saturation, cleared on enter.
`default_nettype none

module iac_entry
    import iac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire iac_step_t          step,
    output logic [ENTRY_W-1:0]      value
);

    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;
    logic [ENTRY_W+3:0] times_ten;

    // value * 10 + digit, as two shifts and adds
    assign times_ten = {1'b0, entry_reg, 3'b000} + {3'b000, entry_reg, 1'b0}
                     + {{(ENTRY_W){1'b0}}, step.key};

    always_comb
    begin
        entry_next = entry_reg;
        if (fire && step.action == ACT_KEY)
        begin
            if (step.key <= KEY_LAST_DIGIT)
            begin
                if (times_ten[ENTRY_W+3:ENTRY_W] != 4'd0)
                begin
                    entry_next = {ENTRY_W{1'b1}};
                end
                else
                begin
                    entry_next = times_ten[ENTRY_W-1:0];
                end
            end
            else if (step.key == KEY_ENTER)
            begin
                entry_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign value = entry_reg;

endmodule

`default_nettype wire

/* design/iac_panel.sv */
// Alarm state: entry resolution, settings, one-second tick and result composition.
`default_nettype none

module iac_panel
    import iac_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire iac_step_t          step,
    input  wire logic [ENTRY_W-1:0] entry_value,
    output iac_result_t             result
);

    logic              armed_reg, armed_next;
    logic              intruded_reg, intruded_next;
    logic              exit_over_reg, exit_over_next;
    logic              parity_reg, parity_next;
    logic [7:0]        siren_secs_reg, siren_secs_next;
    logic [7:0]        exit_secs_reg, exit_secs_next;
    logic [6:0]        arm_code_reg, arm_code_next;
    logic [13:0]       disarm_code_reg, disarm_code_next;
    logic [6:0]        exit_delay_reg, exit_delay_next;
    logic [7:0]        siren_limit_reg, siren_limit_next;
    logic [INST_W-1:0] zone_latch_reg, zone_latch_next;
    logic [DLY_W-1:0]  dly_latch_reg, dly_latch_next;
    logic              siren_reg, siren_next;
    logic              buzzer_reg, buzzer_next;

    msg_t               msg;
    logic               setting;
    logic [SHOWN_W-1:0] setting_value;

    logic               match_arm, match_disarm;
    logic               prog_arm, prog_disarm, prog_exit, prog_siren;
    logic [ENTRY_W-1:0] off_arm, off_disarm, off_exit, off_siren;
    logic [INST_W-1:0]  inst_hit;
    logic [DLY_W-1:0]   dly_hit;

    assign match_arm    = entry_value == {{(ENTRY_W-7){1'b0}}, arm_code_reg};
    assign match_disarm = entry_value == {{(ENTRY_W-14){1'b0}}, disarm_code_reg};
    assign prog_arm     = entry_value >= PROG_ARM_LO    && entry_value <= PROG_ARM_HI;
    assign prog_disarm  = entry_value >= PROG_DISARM_LO && entry_value <= PROG_DISARM_HI;
    assign prog_exit    = entry_value >= PROG_EXIT_LO   && entry_value <= PROG_EXIT_HI;
    assign prog_siren   = entry_value >= PROG_SIREN_LO  && entry_value <= PROG_SIREN_HI;
    assign off_arm      = entry_value - PROG_ARM_LO;
    assign off_disarm   = entry_value - PROG_DISARM_LO;
    assign off_exit     = entry_value - PROG_EXIT_LO;
    assign off_siren    = entry_value - PROG_SIREN_LO;
    assign inst_hit     = step.instant_zones & INST_MASK;
    assign dly_hit      = step.delayed_zones & DLY_MASK;

    always_comb
    begin
        armed_next       = armed_reg;
        intruded_next    = intruded_reg;
        exit_over_next   = exit_over_reg;
        parity_next      = parity_reg;
        siren_secs_next  = siren_secs_reg;
        exit_secs_next   = exit_secs_reg;
        arm_code_next    = arm_code_reg;
        disarm_code_next = disarm_code_reg;
        exit_delay_next  = exit_delay_reg;
        siren_limit_next = siren_limit_reg;
        zone_latch_next  = zone_latch_reg;
        dly_latch_next   = dly_latch_reg;
        siren_next       = siren_reg;
        buzzer_next      = buzzer_reg;
        msg              = MSG_NONE;
        setting_value    = '0;

        if (step.action == ACT_TICK)
        begin
            parity_next = !parity_reg;
            if (armed_reg && exit_secs_reg != SECONDS_MAX)
            begin
                exit_secs_next = exit_secs_reg + 8'd1;
            end
            if (intruded_reg && siren_secs_reg != SECONDS_MAX)
            begin
                siren_secs_next = siren_secs_reg + 8'd1;
            end
            if (armed_reg)
            begin
                if (!exit_over_reg)
                begin
                    // Buzzer sounds on the seconds where the new parity is even
                    buzzer_next = parity_reg;
                end
                if (inst_hit != '0)
                begin
                    zone_latch_next = zone_latch_reg | inst_hit;
                    intruded_next   = 1'b1;
                end
                if (exit_over_reg && dly_hit != '0)
                begin
                    dly_latch_next = dly_latch_reg | dly_hit;
                    intruded_next  = 1'b1;
                end
            end
            siren_next = intruded_next && (siren_secs_next <= siren_limit_reg);
            if (exit_secs_next >= {1'b0, exit_delay_reg} || intruded_next)
            begin
                exit_over_next = 1'b1;
            end
            if (intruded_next)
            begin
                buzzer_next = 1'b0;
            end
        end
        else if (step.key == KEY_ENTER)
        begin
            priority if (match_arm && !armed_reg)
            begin
                armed_next = 1'b1;
                msg        = MSG_ARMED;
            end
            else if ((match_arm && intruded_reg) || (match_disarm && armed_reg))
            begin
                // Clearing an intrusion and disarming leave the panel the same way
                armed_next      = 1'b0;
                intruded_next   = 1'b0;
                siren_secs_next = '0;
                exit_secs_next  = '0;
                exit_over_next  = 1'b0;
                zone_latch_next = '0;
                dly_latch_next  = '0;
                buzzer_next     = 1'b0;
                msg             = (match_arm && intruded_reg) ? MSG_CLEARED : MSG_DISARMED;
            end
            else if (match_disarm)
            begin
                msg = MSG_NOT_ARMED;
            end
            else if (prog_arm)
            begin
                arm_code_next = off_arm[6:0];
                setting_value = {{(SHOWN_W-7){1'b0}}, off_arm[6:0]};
                msg           = MSG_NEW_ARM;
            end
            else if (prog_disarm)
            begin
                disarm_code_next = off_disarm[13:0];
                setting_value    = off_disarm[SHOWN_W-1:0];
                msg              = MSG_NEW_DISARM;
            end
            else if (prog_exit)
            begin
                exit_delay_next = off_exit[6:0];
                setting_value   = {{(SHOWN_W-7){1'b0}}, off_exit[6:0]};
                msg             = MSG_NEW_EXIT;
            end
            else if (prog_siren)
            begin
                if (off_siren[9:0] > SIREN_LIMIT_MAX)
                begin
                    msg = MSG_TOO_LONG;
                end
                else
                begin
                    siren_limit_next = off_siren[7:0];
                    setting_value    = {{(SHOWN_W-8){1'b0}}, off_siren[7:0]};
                    msg              = MSG_NEW_SIREN;
                end
            end
            else if (entry_value == CMD_DEFAULTS)
            begin
                arm_code_next    = ARM_CODE_DEFAULT;
                disarm_code_next = DISARM_CODE_DEFAULT;
                exit_delay_next  = EXIT_DELAY_DEFAULT;
                siren_limit_next = SIREN_LIMIT_DEFAULT;
                msg              = MSG_DEFAULTS;
            end
            else
            begin
                msg = MSG_NONE;
            end
        end
    end

    assign setting = msg == MSG_NEW_ARM || msg == MSG_NEW_DISARM
                  || msg == MSG_NEW_EXIT || msg == MSG_NEW_SIREN;

    always_comb
    begin
        result.armed_led     = armed_next;
        result.siren_on      = siren_next;
        result.buzzer_on     = buzzer_next;
        result.zone_leds     = zone_latch_next;
        result.delayed_leds  = dly_latch_next;
        result.alarm_tripped = intruded_next;
        result.message       = msg;
        result.shown_value   = '0;
        if (setting)
        begin
            result.shown_value = setting_value;
        end
        else if (armed_next && !exit_over_next && {1'b0, exit_delay_next} > exit_secs_next)
        begin
            result.shown_value = {{(SHOWN_W-8){1'b0}},
                                  8'({1'b0, exit_delay_next} - exit_secs_next)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            intruded_reg    <= 1'b0;
            exit_over_reg   <= 1'b0;
            parity_reg      <= 1'b0;
            siren_secs_reg  <= '0;
            exit_secs_reg   <= '0;
            arm_code_reg    <= ARM_CODE_DEFAULT;
            disarm_code_reg <= DISARM_CODE_DEFAULT;
            exit_delay_reg  <= EXIT_DELAY_DEFAULT;
            siren_limit_reg <= SIREN_LIMIT_DEFAULT;
            zone_latch_reg  <= '0;
            dly_latch_reg   <= '0;
            siren_reg       <= 1'b0;
            buzzer_reg      <= 1'b0;
        end
        else if (fire)
        begin
            armed_reg       <= armed_next;
            intruded_reg    <= intruded_next;
            exit_over_reg   <= exit_over_next;
            parity_reg      <= parity_next;
            siren_secs_reg  <= siren_secs_next;
            exit_secs_reg   <= exit_secs_next;
            arm_code_reg    <= arm_code_next;
            disarm_code_reg <= disarm_code_next;
            exit_delay_reg  <= exit_delay_next;
            siren_limit_reg <= siren_limit_next;
            zone_latch_reg  <= zone_latch_next;
            dly_latch_reg   <= dly_latch_next;
            siren_reg       <= siren_next;
            buzzer_reg      <= buzzer_next;
        end
    end

endmodule

`default_nettype wire

/* bench/intrusion_alarm_controller_top_tb.sv */
// Self-checking testbench for the intrusion alarm controller top level.

module intrusion_alarm_controller_top_tb;
    import iac_pkg::*;

    // Largest value the key field can carry; codes above enter are ignored by the panel.
    localparam logic [KEY_W-1:0] KEY_TOP = 4'd15;
    // Least number of items offered in each random phase.
    localparam int PHASE_ITEMS = 335;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLD_OFF_CYCLES = 60;
    // Cycles waited after the drain, before the final check.
    localparam int SETTLE_CYCLES = 8;
    // Only the first mismatches are printed; every one is counted.
    localparam int PRINT_LIMIT = 40;

    logic clk;
    logic rst_n;

    iac_item_if   item_ch ();
    iac_result_if result_ch ();

    intrusion_alarm_controller_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // A row of the directed table: the item and, where it is obvious, its result.
    typedef struct {
        iac_step_t   step;
        bit          pinned;
        iac_result_t want;
    } stim_row_t;

    stim_row_t   directed_rows [$];
    iac_step_t   planned [$];
    iac_result_t due_results [$];

    int send_idle_by_phase [3] = '{9, 68, 0};
    int recv_idle_by_phase [3] = '{68, 9, 0};
    int send_idle_pct = 9;
    int recv_idle_pct = 68;
    int hold_left     = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    bit entry_dirty   = 0;

    // Shadow copy of the panel state, advanced once per accepted transfer.
    logic [ENTRY_W-1:0] entry_value;
    bit                 panel_armed;
    bit                 intrusion;
    bit                 exit_done;
    bit                 parity;
    bit                 siren_lit;
    bit                 buzzer_lit;
    logic [7:0]         siren_count;
    logic [7:0]         exit_count;
    logic [6:0]         cur_arm_code;
    logic [13:0]        cur_disarm_code;
    logic [6:0]         cur_exit_delay;
    logic [7:0]         cur_siren_limit;
    logic [INST_W-1:0]  zone_latch;
    logic [DLY_W-1:0]   delayed_latch;

    // ------------------------------------------------------------------
    // Panel predictor
    // ------------------------------------------------------------------

    function automatic void load_panel_defaults();
        cur_arm_code    = ARM_CODE_DEFAULT;
        cur_disarm_code = DISARM_CODE_DEFAULT;
        cur_siren_limit = SIREN_LIMIT_DEFAULT;
        cur_exit_delay  = EXIT_DELAY_DEFAULT;
    endfunction

    // Clearing the system leaves the siren drive alone until the next tick.
    function automatic void clear_panel();
        panel_armed   = 1'b0;
        intrusion     = 1'b0;
        siren_count   = '0;
        exit_count    = '0;
        exit_done     = 1'b0;
        zone_latch    = '0;
        delayed_latch = '0;
        buzzer_lit    = 1'b0;
    endfunction

    function automatic void reset_panel();
        entry_value = '0;
        parity      = 1'b0;
        siren_lit   = 1'b0;
        clear_panel();
        load_panel_defaults();
    endfunction

    // Resolves an entered value; the order of the tests is the priority of the rules.
    function automatic msg_t resolve_entry(input logic [ENTRY_W-1:0] v,
                                           output logic [SHOWN_W-1:0] shown);
        logic [ENTRY_W-1:0] part;
        shown = '0;
        if (v == cur_arm_code && !panel_armed)
        begin
            panel_armed = 1'b1;
            return MSG_ARMED;
        end
        if (v == cur_arm_code && intrusion && panel_armed)
        begin
            clear_panel();
            return MSG_CLEARED;
        end
        if (v == cur_disarm_code && panel_armed)
        begin
            clear_panel();
            return MSG_DISARMED;
        end
        if (v == cur_disarm_code)
            return MSG_NOT_ARMED;
        if (v >= PROG_ARM_LO && v <= PROG_ARM_HI)
        begin
            part = v - PROG_ARM_LO;
            cur_arm_code = part[6:0];
            shown = SHOWN_W'(cur_arm_code);
            return MSG_NEW_ARM;
        end
        if (v >= PROG_DISARM_LO && v <= PROG_DISARM_HI)
        begin
            part = v - PROG_DISARM_LO;
            cur_disarm_code = part[13:0];
            shown = SHOWN_W'(cur_disarm_code);
            return MSG_NEW_DISARM;
        end
        if (v >= PROG_EXIT_LO && v <= PROG_EXIT_HI)
        begin
            part = v - PROG_EXIT_LO;
            cur_exit_delay = part[6:0];
            shown = SHOWN_W'(cur_exit_delay);
            return MSG_NEW_EXIT;
        end
        if (v >= PROG_SIREN_LO && v <= PROG_SIREN_HI)
        begin
            part = v - PROG_SIREN_LO;
            if (part > SIREN_LIMIT_MAX)
                return MSG_TOO_LONG;
            cur_siren_limit = part[7:0];
            shown = SHOWN_W'(cur_siren_limit);
            return MSG_NEW_SIREN;
        end
        if (v == CMD_DEFAULTS)
        begin
            load_panel_defaults();
            return MSG_DEFAULTS;
        end
        return MSG_NONE;
    endfunction

    function automatic void tick_panel(input logic [INST_W-1:0] inst, input logic [DLY_W-1:0] dly);
        bit was_over;
        was_over = exit_done;
        parity = !parity;
        if (panel_armed && exit_count < SECONDS_MAX)
            exit_count = exit_count + 8'd1;
        if (intrusion && siren_count < SECONDS_MAX)
            siren_count = siren_count + 8'd1;
        if (panel_armed)
        begin
            if (!exit_done)
                buzzer_lit = !parity;
            if ((inst & INST_MASK) != '0)
            begin
                zone_latch = zone_latch | (inst & INST_MASK);
                intrusion  = 1'b1;
            end
            // Delayed zones only count once the exit delay was over before this tick.
            if (was_over && (dly & DLY_MASK) != '0)
            begin
                delayed_latch = delayed_latch | (dly & DLY_MASK);
                intrusion     = 1'b1;
            end
        end
        siren_lit = intrusion && (siren_count <= cur_siren_limit);
        if (exit_count >= cur_exit_delay)
            exit_done = 1'b1;
        if (intrusion)
        begin
            exit_done  = 1'b1;
            buzzer_lit = 1'b0;
        end
    endfunction

    function automatic iac_result_t advance_panel(input iac_step_t s);
        iac_result_t        r;
        logic [63:0]        grown;
        logic [ENTRY_W-1:0] entered;
        msg_t               msg;
        logic [SHOWN_W-1:0] shown;
        bit                 setting;
        msg     = MSG_NONE;
        shown   = '0;
        setting = 1'b0;
        if (s.action == ACT_KEY)
        begin
            if (s.key <= KEY_LAST_DIGIT)
            begin
                grown = 64'(entry_value) * 64'd10 + 64'(s.key);
                entry_value = (grown > 64'hFFFF_FFFF) ? '1 : grown[31:0];
            end
            else if (s.key == KEY_ENTER)
            begin
                entered     = entry_value;
                entry_value = '0;
                msg         = resolve_entry(entered, shown);
                setting     = (msg >= MSG_NEW_ARM) && (msg <= MSG_NEW_SIREN);
            end
        end
        else
        begin
            tick_panel(s.instant_zones, s.delayed_zones);
        end
        if (!setting)
        begin
            shown = '0;
            if (panel_armed && !exit_done && cur_exit_delay > exit_count)
                shown = SHOWN_W'(cur_exit_delay - exit_count);
        end
        r.armed_led     = panel_armed;
        r.siren_on      = siren_lit;
        r.buzzer_on     = buzzer_lit;
        r.zone_leds     = zone_latch;
        r.delayed_leds  = delayed_latch;
        r.alarm_tripped = intrusion;
        r.message       = msg;
        r.shown_value   = shown;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fields that the action does not use are always random.
    function automatic iac_step_t key_step(input logic [KEY_W-1:0] k);
        iac_step_t s;
        s.action        = ACT_KEY;
        s.key           = k;
        s.instant_zones = INST_W'($urandom);
        s.delayed_zones = DLY_W'($urandom);
        return s;
    endfunction

    function automatic iac_step_t tick_step(input logic [INST_W-1:0] inst,
                                            input logic [DLY_W-1:0] dly);
        iac_step_t s;
        s.action        = ACT_TICK;
        s.key           = KEY_W'($urandom);
        s.instant_zones = inst;
        s.delayed_zones = dly;
        return s;
    endfunction

    // Sensors are mostly quiet, so that an armed panel survives several seconds.
    function automatic logic [INST_W-1:0] sparse_instant();
        return ($urandom_range(0, 9) == 0) ? INST_W'($urandom_range(1, 15)) : '0;
    endfunction

    function automatic logic [DLY_W-1:0] sparse_delayed();
        return ($urandom_range(0, 7) == 0) ? DLY_W'($urandom_range(1, 3)) : '0;
    endfunction

    function automatic iac_result_t plain_result(input logic armed, input msg_t msg,
                                                 input logic [SHOWN_W-1:0] shown);
        iac_result_t r;
        r             = '0;
        r.armed_led   = armed;
        r.message     = msg;
        r.shown_value = shown;
        return r;
    endfunction

    function automatic void add_key_row(input logic [KEY_W-1:0] k, input bit pinned,
                                        input iac_result_t want);
        stim_row_t row;
        row.step   = key_step(k);
        row.pinned = pinned;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_tick_row(input logic [INST_W-1:0] inst,
                                         input logic [DLY_W-1:0] dly, input bit pinned,
                                         input iac_result_t want);
        stim_row_t row;
        row.step   = tick_step(inst, dly);
        row.pinned = pinned;
        row.want   = want;
        directed_rows.push_back(row);
    endfunction

    // Plans the keystrokes of a whole entry, clearing any half-typed digits first.
    function automatic void plan_number(input logic [ENTRY_W-1:0] v);
        logic [KEY_W-1:0] digits [$];
        if (entry_dirty)
        begin
            planned.push_back(key_step(KEY_ENTER));
            entry_dirty = 1'b0;
        end
        do
        begin
            digits.push_front(KEY_W'(v % 10));
            v = v / 10;
        end
        while (v != 0);
        if ($urandom_range(0, 9) == 0)
            planned.push_back(key_step('0));
        foreach (digits[i])
            planned.push_back(key_step(digits[i]));
        planned.push_back(key_step(KEY_ENTER));
    endfunction

    function automatic void plan_sequence();
        int roll;
        int n;
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            n = $urandom_range(1, 4);
            repeat (n) planned.push_back(tick_step(sparse_instant(), sparse_delayed()));
        end
        else if (roll < 42)
            plan_number(ENTRY_W'(cur_arm_code));
        else if (roll < 52)
            plan_number(ENTRY_W'(cur_disarm_code));
        else if (roll < 56)
            plan_number(PROG_ARM_LO + ENTRY_W'($urandom_range(0, 99)));
        else if (roll < 60)
            plan_number(PROG_DISARM_LO + (($urandom_range(0, 3) == 0) ? 32'd9999 :
                                          ENTRY_W'($urandom_range(0, 9999))));
        else if (roll < 65)
            plan_number(PROG_EXIT_LO + (($urandom_range(0, 3) != 0) ?
                                        ENTRY_W'($urandom_range(0, 6)) :
                                        ENTRY_W'($urandom_range(0, 99))));
        else if (roll < 70)
        begin
            case ($urandom_range(0, 2))
                0:       plan_number(PROG_SIREN_LO + ENTRY_W'($urandom_range(0, 10)));
                1:       plan_number(PROG_SIREN_LO + ENTRY_W'($urandom_range(170, 200)));
                default: plan_number(PROG_SIREN_LO + ENTRY_W'($urandom_range(0, 999)));
            endcase
        end
        else if (roll < 72)
            plan_number(CMD_DEFAULTS);
        else if (roll < 74)
        begin
            // Ten to twelve digits; eleven or more drive the entry into saturation.
            if (entry_dirty)
                planned.push_back(key_step(KEY_ENTER));
            entry_dirty = 1'b0;
            n = $urandom_range(10, 12);
            planned.push_back(key_step(KEY_W'($urandom_range(1, 9))));
            repeat (n - 1) planned.push_back(key_step(KEY_W'($urandom_range(0, 9))));
            planned.push_back(key_step(KEY_ENTER));
        end
        else if (roll < 75)
        begin
            // A long run of seconds lets the exit and siren counters reach saturation.
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 280) : $urandom_range(20, 60);
            repeat (n) planned.push_back(tick_step(sparse_instant(), sparse_delayed()));
        end
        else if (roll < 85)
        begin
            // An entry abandoned before enter.
            n = $urandom_range(1, 3);
            repeat (n) planned.push_back(key_step(KEY_W'($urandom_range(0, 9))));
            entry_dirty = 1'b1;
        end
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                if ($urandom_range(0, 1) == 0)
                    planned.push_back(key_step(KEY_W'($urandom_range(0, 15))));
                else
                    planned.push_back(tick_step(INST_W'($urandom), DLY_W'($urandom)));
            end
            entry_dirty = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                      results_seen, name, got, want));
    endtask

    // Offers one item, waits for its transfer and records the result it must cause.
    // Valid is only lowered for an idle cycle, so it never gets two updates in one step.
    task automatic offer_item(input iac_step_t s, input bit pinned, input iac_result_t want);
        iac_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= s.action;
        item_ch.key           <= s.key;
        item_ch.instant_zones <= s.instant_zones;
        item_ch.delayed_zones <= s.delayed_zones;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = advance_panel(s);
        due_results.push_back(pinned ? want : predicted);
        items_sent++;
    endtask

    // The sender stops offering until every outstanding result has been taken.
    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver: stalls at random, and once holds off for a long stretch so that the block
    // fills both of its registers and has to refuse further items.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every result transfer is compared, field by field, with the oldest expected result.
    always @(posedge clk)
    begin : result_check
        iac_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_results.size() == 0)
            begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("armed_led", 32'(result_ch.armed_led), 32'(want.armed_led));
                compare_field("siren_on", 32'(result_ch.siren_on), 32'(want.siren_on));
                compare_field("buzzer_on", 32'(result_ch.buzzer_on), 32'(want.buzzer_on));
                compare_field("zone_leds", 32'(result_ch.zone_leds), 32'(want.zone_leds));
                compare_field("delayed_leds", 32'(result_ch.delayed_leds),
                              32'(want.delayed_leds));
                compare_field("alarm_tripped", 32'(result_ch.alarm_tripped),
                              32'(want.alarm_tripped));
                compare_field("message", 32'(result_ch.message), 32'(want.message));
                compare_field("shown_value", 32'(result_ch.shown_value),
                              32'(want.shown_value));
            end
            results_seen++;
        end
    end

    // Main sequence: reset, the directed table, three random phases, then the drain.
    initial
    begin
        int phase_end;
        iac_result_t quiet;
        quiet = plain_result(1'b0, MSG_NONE, '0);

        rst_n                 <= 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.action        <= ACT_KEY;
        item_ch.key           <= '0;
        item_ch.instant_zones <= '0;
        item_ch.delayed_zones <= '0;
        reset_panel();

        // Directed table. Rows up to the arming have results that are plain
        // from the defaults; later rows are left to the predictor.
        add_key_row(KEY_ENTER, 1'b1, quiet);
        add_key_row(KEY_STAR, 1'b1, quiet);
        add_key_row(KEY_TOP, 1'b1, quiet);
        add_tick_row('1, '1, 1'b1, quiet);
        add_key_row(4'd3, 1'b1, quiet);
        add_key_row(4'd0, 1'b1, quiet);
        add_key_row(4'd1, 1'b1, quiet);
        add_key_row(4'd8, 1'b1, quiet);
        add_key_row(4'd1, 1'b1, quiet);
        add_key_row(KEY_ENTER, 1'b1, plain_result(1'b0, MSG_TOO_LONG, '0));
        add_key_row(4'd3, 1'b1, quiet);
        add_key_row(4'd3, 1'b1, quiet);
        add_key_row(KEY_ENTER, 1'b1,
                    plain_result(1'b1, MSG_ARMED, SHOWN_W'(EXIT_DELAY_DEFAULT)));
        // A delayed zone during the exit delay is ignored; an instant zone trips at once.
        add_tick_row('0, '1, 1'b0, quiet);
        add_tick_row(4'b1000, '0, 1'b0, quiet);
        add_key_row(4'd3, 1'b0, quiet);
        add_key_row(4'd3, 1'b0, quiet);
        add_key_row(KEY_ENTER, 1'b0, quiet);
        add_key_row(4'd9, 1'b0, quiet);
        add_key_row(4'd9, 1'b0, quiet);
        add_key_row(4'd0, 1'b0, quiet);
        add_key_row(4'd0, 1'b0, quiet);
        add_key_row(4'd0, 1'b0, quiet);
        add_key_row(KEY_ENTER, 1'b0, quiet);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_item(directed_rows[i].step, directed_rows[i].pinned, directed_rows[i].want);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase > 0)
                wait_for_results();
            send_idle_pct = send_idle_by_phase[phase];
            recv_idle_pct = recv_idle_by_phase[phase];
            if (phase == 2)
                hold_left = HOLD_OFF_CYCLES;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                plan_sequence();
                while (planned.size() != 0)
                    offer_item(planned.pop_front(), 1'b0, quiet);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
